// ----- src/ordered_tx_queue_phase_dequeue_core_assert.svh -----
// assertion macros for the ordered transmit queue core
// expects clk and rst in the scope where the macros are used
`ifndef ORDERED_TX_QUEUE_PHASE_DEQUEUE_CORE_ASSERT_SVH
`define ORDERED_TX_QUEUE_PHASE_DEQUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define OTQ_CHK_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OTQ_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/otq_pkg.sv -----
// shared types and codes for the ordered transmit queue
// no dependencies
`timescale 1ns / 1ps

package otq_pkg;

  localparam int ACT_W = 2;
  localparam int LID_W = 8;
  localparam int PH_W  = 2;
  localparam int STS_W = 2;
  localparam int THR_W = 6;

  localparam logic [THR_W-1:0] THR_RESET = 6'd32;

  localparam logic [ACT_W-1:0] ACT_ORD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_HEAD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DEQ   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAN = 2'd3;

  localparam logic [STS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [PH_W-1:0] PH_NONE = 2'd0;

  typedef struct packed {
    logic lid_hit;
    logic phase_hit;
  } cmp_res_t;

  typedef struct packed {
    logic             idle;
    logic             done;
    logic [STS_W-1:0] status;
  } seq_stat_t;

endpackage

// ----- src/otq_cmp.sv -----
// shared compare unit: lid order test and phase match on one slot
// depends on otq_pkg
`timescale 1ns / 1ps

module otq_cmp import otq_pkg::*; (
  input  logic [LID_W-1:0] slot_lid,
  input  logic [PH_W-1:0]  slot_phase,
  input  logic [LID_W-1:0] key_lid,
  input  logic [PH_W-1:0]  key_phase,
  output cmp_res_t         res
);

  assign res.lid_hit   = (key_lid <= slot_lid);
  assign res.phase_hit = (key_phase == PH_NONE) || (slot_phase == PH_NONE) ||
                         (slot_phase == key_phase);

endmodule

// ----- src/otq_slot_ram.sv -----
// slot store: one write port, one registered read port
// no package dependencies
`timescale 1ns / 1ps

module otq_slot_ram #(
  parameter int DEPTH = 32,
  parameter int W     = 26,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/otq_seq.sv -----
// sequencer: walks the slot store one entry at a time for scan, shift and search
// depends on otq_pkg and otq_cmp
`timescale 1ns / 1ps

module otq_seq import otq_pkg::*; #(
  parameter int CAPACITY = 32,
  parameter int TAG_BITS = 16,
  localparam int CNT_W   = $clog2(CAPACITY + 1),
  localparam int AW      = $clog2(CAPACITY),
  localparam int ENT_W   = TAG_BITS + LID_W + PH_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [ACT_W-1:0]    action,
  input  logic [TAG_BITS-1:0] new_tag,
  input  logic [LID_W-1:0]    new_lid,
  input  logic [PH_W-1:0]     new_phase,
  input  logic [PH_W-1:0]     req_phase,
  input  logic [THR_W-1:0]    thr,
  input  logic                take,
  output seq_stat_t           stat,
  output logic [TAG_BITS-1:0] res_tag,
  output logic [LID_W-1:0]    res_lid,
  output logic [PH_W-1:0]     res_phase,
  output logic [CNT_W-1:0]    fill,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [ENT_W-1:0]    ram_wdata,
  output logic [AW-1:0]       ram_raddr,
  input  logic [ENT_W-1:0]    ram_rdata
);

  localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN_RD  = 4'd1;
  localparam logic [3:0] S_SCAN_CHK = 4'd2;
  localparam logic [3:0] S_SHUP_RD  = 4'd3;
  localparam logic [3:0] S_SHUP_WR  = 4'd4;
  localparam logic [3:0] S_PUT      = 4'd5;
  localparam logic [3:0] S_FIND_RD  = 4'd6;
  localparam logic [3:0] S_FIND_CHK = 4'd7;
  localparam logic [3:0] S_SHDN_RD  = 4'd8;
  localparam logic [3:0] S_SHDN_WR  = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0]          state;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    pos;
  logic [TAG_BITS-1:0] tag_r;
  logic [LID_W-1:0]    lid_r;
  logic [PH_W-1:0]     phase_r;
  logic [PH_W-1:0]     req_r;
  logic [STS_W-1:0]    sts;

  logic [CNT_W-1:0]    idx_dec;
  logic [CNT_W-1:0]    idx_inc;
  logic [CNT_W-1:0]    fill_dec;
  logic                full_cap;
  logic                full_thr;
  logic [TAG_BITS-1:0] rd_tag;
  logic [LID_W-1:0]    rd_lid;
  logic [PH_W-1:0]     rd_phase;
  cmp_res_t            cmp;

  assign idx_dec  = idx - CNT_W'(1);
  assign idx_inc  = idx + CNT_W'(1);
  assign fill_dec = fill - CNT_W'(1);
  assign full_cap = (fill == CNT_W'(CAPACITY));
  assign full_thr = (CMP_W'(fill) >= CMP_W'(thr));

  assign rd_tag   = ram_rdata[ENT_W-1 -: TAG_BITS];
  assign rd_lid   = ram_rdata[PH_W +: LID_W];
  assign rd_phase = ram_rdata[PH_W-1:0];

  otq_cmp u_cmp (
    .slot_lid   (rd_lid),
    .slot_phase (rd_phase),
    .key_lid    (lid_r),
    .key_phase  (req_r),
    .res        (cmp)
  );

  // store port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx[AW-1:0];
    unique case (state)
      S_SCAN_RD, S_SHUP_RD: ram_raddr = idx_dec[AW-1:0];
      S_SHDN_RD:            ram_raddr = idx_inc[AW-1:0];
      S_SHUP_WR, S_SHDN_WR: ram_we    = 1'b1;
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos[AW-1:0];
        ram_wdata = {tag_r, lid_r, phase_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            tag_r     <= new_tag;
            lid_r     <= new_lid;
            phase_r   <= new_phase;
            req_r     <= req_phase;
            res_tag   <= '0;
            res_lid   <= '0;
            res_phase <= '0;
            sts       <= ST_OK;
            unique case (action)
              ACT_ORD: begin
                if (full_thr || full_cap) begin
                  sts   <= ST_FULL;
                  state <= S_DONE;
                end else if (fill == '0) begin
                  pos   <= '0;
                  state <= S_PUT;
                end else begin
                  idx   <= fill;
                  pos   <= fill;
                  state <= S_SCAN_RD;
                end
              end
              ACT_HEAD: begin
                if (full_cap) begin
                  sts   <= ST_FULL;
                  state <= S_DONE;
                end else begin
                  pos   <= '0;
                  idx   <= fill;
                  state <= (fill == '0) ? S_PUT : S_SHUP_RD;
                end
              end
              ACT_DEQ: begin
                if (fill == '0) begin
                  sts   <= ST_EMPTY;
                  state <= S_DONE;
                end else begin
                  idx   <= '0;
                  state <= S_FIND_RD;
                end
              end
              ACT_CLEAN: begin
                fill  <= '0;
                state <= S_DONE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SCAN_RD: state <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          // first slot from the tail with lid at least the new one
          if (cmp.lid_hit) begin
            pos   <= idx_dec;
            idx   <= fill;
            state <= S_SHUP_RD;
          end else if (idx == CNT_W'(1)) begin
            state <= S_PUT;
          end else begin
            idx   <= idx_dec;
            state <= S_SCAN_RD;
          end
        end
        S_SHUP_RD: state <= S_SHUP_WR;
        S_SHUP_WR: begin
          if (idx_dec == pos) begin
            state <= S_PUT;
          end else begin
            idx   <= idx_dec;
            state <= S_SHUP_RD;
          end
        end
        S_PUT: begin
          fill  <= fill + CNT_W'(1);
          state <= S_DONE;
        end
        S_FIND_RD: state <= S_FIND_CHK;
        S_FIND_CHK: begin
          if (cmp.phase_hit) begin
            res_tag   <= rd_tag;
            res_lid   <= rd_lid;
            res_phase <= rd_phase;
            if (idx_inc < fill) begin
              state <= S_SHDN_RD;
            end else begin
              fill  <= fill_dec;
              state <= S_DONE;
            end
          end else if (idx_inc == fill) begin
            sts   <= ST_EMPTY;
            state <= S_DONE;
          end else begin
            idx   <= idx_inc;
            state <= S_FIND_RD;
          end
        end
        S_SHDN_RD: state <= S_SHDN_WR;
        S_SHDN_WR: begin
          idx <= idx_inc;
          if (idx_inc < fill_dec) begin
            state <= S_SHDN_RD;
          end else begin
            fill  <= fill_dec;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.idle   = (state == S_IDLE);
  assign stat.done   = (state == S_DONE);
  assign stat.status = sts;

endmodule

// ----- src/ordered_tx_queue_phase_dequeue_core.sv -----
// top level of the ordered transmit queue with phase-filtered dequeue
// depends on otq_pkg, otq_slot_ram, otq_seq and the assertion macro header
`timescale 1ns / 1ps

// Holds up to CAPACITY entries (tag, lid, phase) in one single-port-read slot
// RAM, head at slot 0. One action is taken at a time: the input stalls from
// the accepting edge until the result beat has been placed in the output
// register. Every slot visit is a registered read, then a compare or write:
// ordered enqueue scans from the tail, then shifts up; head enqueue shifts
// up; dequeue searches from the head, then shifts down; clean and dropped
// actions finish with no slot visit. The output register lets the next beat
// be accepted while a result still waits downstream. No clearing pass after
// reset: the store is only read below the entry count.
module ordered_tx_queue_phase_dequeue_core import otq_pkg::*; #(
  parameter int CAPACITY = 32,
  parameter int TAG_BITS = 16,
  localparam int CNT_W   = $clog2(CAPACITY + 1),
  localparam int AW      = $clog2(CAPACITY),
  localparam int ENT_W   = TAG_BITS + LID_W + PH_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [THR_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ACT_W-1:0]    action,
  input  logic [TAG_BITS-1:0] new_tag,
  input  logic [LID_W-1:0]    new_lid,
  input  logic [PH_W-1:0]     new_phase,
  input  logic [PH_W-1:0]     req_phase,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STS_W-1:0]    status,
  output logic [TAG_BITS-1:0] out_tag,
  output logic [LID_W-1:0]    out_lid,
  output logic [PH_W-1:0]     out_phase,
  output logic [CNT_W-1:0]    entry_total
);

`include "ordered_tx_queue_phase_dequeue_core_assert.svh"

  logic [THR_W-1:0]    thr;
  seq_stat_t           stat;
  logic [TAG_BITS-1:0] res_tag;
  logic [LID_W-1:0]    res_lid;
  logic [PH_W-1:0]     res_phase;
  logic [CNT_W-1:0]    fill;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [ENT_W-1:0]    ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [ENT_W-1:0]    ram_rdata;
  logic                start;
  logic                load;

  assign in_stall = !stat.idle;
  assign start    = in_valid && !in_stall;
  // output slot free, or its beat leaves this cycle
  assign load     = stat.done && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_data;
    end
  end

  otq_slot_ram #(
    .DEPTH (CAPACITY),
    .W     (ENT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  otq_seq #(
    .CAPACITY (CAPACITY),
    .TAG_BITS (TAG_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .action    (action),
    .new_tag   (new_tag),
    .new_lid   (new_lid),
    .new_phase (new_phase),
    .req_phase (req_phase),
    .thr       (thr),
    .take      (load),
    .stat      (stat),
    .res_tag   (res_tag),
    .res_lid   (res_lid),
    .res_phase (res_phase),
    .fill      (fill),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status      <= stat.status;
      out_tag     <= res_tag;
      out_lid     <= res_lid;
      out_phase   <= res_phase;
      entry_total <= fill;
    end
  end

  `OTQ_CHK_NEXT(a_accept_busy, start, !stat.idle, "sequencer idle after an accepted beat")
  `OTQ_CHK_IMPL(a_fill_bound, 1'b1, fill <= CNT_W'(CAPACITY), "entry count above capacity")
  `OTQ_CHK_IMPL(a_fail_no_entry, out_valid && (status != ST_OK), (out_tag == '0) && (out_lid == '0) && (out_phase == '0), "entry fields set on a failed action")
  `OTQ_CHK_IMPL(a_result_source, $rose(out_valid), $past(stat.done), "result beat without a finished action")

endmodule

// ----- tb/otq_checker.sv -----
// scoreboard for the ordered transmit queue: watches both beat channels and the threshold port
// keeps its own model of the queue and compares every result beat; depends on otq_pkg
`timescale 1ns / 1ps

module otq_checker import otq_pkg::*; #(
  parameter int CAPACITY = 32,
  parameter int TAG_BITS = 16,
  parameter int CNT_W    = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [THR_W-1:0]    cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [ACT_W-1:0]    action,
  input  logic [TAG_BITS-1:0] new_tag,
  input  logic [LID_W-1:0]    new_lid,
  input  logic [PH_W-1:0]     new_phase,
  input  logic [PH_W-1:0]     req_phase,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [STS_W-1:0]    status,
  input  logic [TAG_BITS-1:0] out_tag,
  input  logic [LID_W-1:0]    out_lid,
  input  logic [PH_W-1:0]     out_phase,
  input  logic [CNT_W-1:0]    entry_total,
  output int                  mismatch_count,
  output int                  outstanding
);

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [LID_W-1:0]    lid;
    logic [PH_W-1:0]     phase;
  } entry_t;

  typedef struct packed {
    logic [STS_W-1:0]    status;
    logic [TAG_BITS-1:0] tag;
    logic [LID_W-1:0]    lid;
    logic [PH_W-1:0]     phase;
    logic [CNT_W-1:0]    total;
  } outcome_t;

  entry_t           line_up[$];   // head at index 0
  outcome_t         awaited[$];
  logic [THR_W-1:0] drop_level = THR_RESET;
  int               bad_beats = 0;

  function automatic outcome_t take_action(input logic [ACT_W-1:0] act,
                                           input entry_t ent,
                                           input logic [PH_W-1:0] req);
    outcome_t res;
    int       pos;
    int       hit;
    res = '0;
    case (act)
      ACT_ORD: begin
        if (line_up.size() >= drop_level || line_up.size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // walk from the tail, land before the first entry with lid not below ours
          pos = line_up.size();
          for (int i = line_up.size(); i > 0; i--) begin
            if (ent.lid <= line_up[i-1].lid) begin
              pos = i - 1;
              break;
            end
          end
          line_up.insert(pos, ent);
        end
      end
      ACT_HEAD: begin
        if (line_up.size() >= CAPACITY) res.status = ST_FULL;
        else line_up.push_front(ent);
      end
      ACT_DEQ: begin
        hit = -1;
        for (int i = 0; i < line_up.size(); i++) begin
          if (req == PH_NONE || line_up[i].phase == PH_NONE || line_up[i].phase == req) begin
            hit = i;
            break;
          end
        end
        if (hit < 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.tag   = line_up[hit].tag;
          res.lid   = line_up[hit].lid;
          res.phase = line_up[hit].phase;
          line_up.delete(hit);
        end
      end
      default: line_up.delete();
    endcase
    res.total = CNT_W'(line_up.size());
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t seen;
    outcome_t want;
    if (rst) begin
      line_up.delete();
      awaited.delete();
      drop_level = THR_RESET;
    end else begin
      if (in_valid && !in_stall)
        awaited.push_back(take_action(action,
                                      '{tag: new_tag, lid: new_lid, phase: new_phase},
                                      req_phase));
      if (out_valid && !out_stall) begin
        seen = '{status: status, tag: out_tag, lid: out_lid, phase: out_phase,
                 total: entry_total};
        if (awaited.size() == 0) begin
          bad_beats++;
          if (bad_beats <= 10)
            $display("%0t: result beat with nothing awaited: sts %0d tag %h lid %0d ph %0d n %0d",
                     $realtime, seen.status, seen.tag, seen.lid, seen.phase, seen.total);
        end else begin
          want = awaited.pop_front();
          if (seen.status != want.status || seen.tag != want.tag || seen.lid != want.lid ||
              seen.phase != want.phase || seen.total != want.total) begin
            bad_beats++;
            if (bad_beats <= 10)
              $display("%0t: bad beat: want sts %0d tag %h lid %0d ph %0d n %0d, got sts %0d tag %h lid %0d ph %0d n %0d",
                       $realtime, want.status, want.tag, want.lid, want.phase, want.total,
                       seen.status, seen.tag, seen.lid, seen.phase, seen.total);
          end
        end
      end
      // threshold writes only happen while idle, so after the beat is fine
      if (cfg_we) drop_level = cfg_data;
    end
    mismatch_count <= bad_beats;
    outstanding    <= awaited.size();
  end

endmodule

// ----- tb/tb_ordered_tx_queue_phase_dequeue_core.sv -----
// stimulus and verdict for the ordered transmit queue core
// depends on otq_pkg, the core and otq_checker, which does all the prediction and comparing
`timescale 1ns / 1ps

module tb_ordered_tx_queue_phase_dequeue_core import otq_pkg::*;;

  localparam int TAG_BITS        = 16;
  localparam int CAPACITY        = 32;
  localparam int CNT_W           = 6;
  localparam int ITEMS_PER_PHASE = 400;
  localparam int STALL_LIMIT     = 4000;
  localparam int TAIL_CYCLES     = 140;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_we    = 1'b0;
  logic [THR_W-1:0]    cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [ACT_W-1:0]    action    = ACT_CLEAN;
  logic [TAG_BITS-1:0] new_tag   = '0;
  logic [LID_W-1:0]    new_lid   = '0;
  logic [PH_W-1:0]     new_phase = PH_NONE;
  logic [PH_W-1:0]     req_phase = PH_NONE;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STS_W-1:0]    status;
  logic [TAG_BITS-1:0] out_tag;
  logic [LID_W-1:0]    out_lid;
  logic [PH_W-1:0]     out_phase;
  logic [CNT_W-1:0]    entry_total;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int mismatch_count;
  int outstanding;

  ordered_tx_queue_phase_dequeue_core uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .new_tag     (new_tag),
    .new_lid     (new_lid),
    .new_phase   (new_phase),
    .req_phase   (req_phase),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .out_tag     (out_tag),
    .out_lid     (out_lid),
    .out_phase   (out_phase),
    .entry_total (entry_total)
  );

  otq_checker #(.CAPACITY(CAPACITY), .TAG_BITS(TAG_BITS), .CNT_W(CNT_W)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .new_tag        (new_tag),
    .new_lid        (new_lid),
    .new_phase      (new_phase),
    .req_phase      (req_phase),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .out_tag        (out_tag),
    .out_lid        (out_lid),
    .out_phase      (out_phase),
    .entry_total    (entry_total),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // ends the run if neither channel moves a beat for too long
  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run = 0;
      else idle_run++;
    end
    $display("Mismatches found");
    $finish;
  end

  // returns in the cycle the beat is taken; valid stays up for a following beat
  task automatic send_beat(input logic [ACT_W-1:0] act, input logic [TAG_BITS-1:0] tag,
                           input logic [LID_W-1:0] lid, input logic [PH_W-1:0] ph,
                           input logic [PH_W-1:0] req);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    new_tag   <= tag;
    new_lid   <= lid;
    new_phase <= ph;
    req_phase <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // narrow lids half the time so that equal ids turn up often
  function automatic logic [LID_W-1:0] rand_lid();
    return $urandom_range(1) ? LID_W'($urandom_range(7)) : LID_W'($urandom_range(255));
  endfunction

  task automatic send_random(input bit filling);
    int               pick;
    logic [ACT_W-1:0] act;
    pick = $urandom_range(99);
    if (filling)
      act = pick < 58 ? ACT_ORD : pick < 73 ? ACT_HEAD : pick < 99 ? ACT_DEQ : ACT_CLEAN;
    else
      act = pick < 15 ? ACT_ORD : pick < 20 ? ACT_HEAD : pick < 98 ? ACT_DEQ : ACT_CLEAN;
    send_beat(act, TAG_BITS'($urandom_range(16'hFFFF)), rand_lid(),
              PH_W'($urandom_range(3)), PH_W'($urandom_range(3)));
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] thr);
    cfg_we   <= 1'b1;
    cfg_data <= thr;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input bit write_thr, input logic [THR_W-1:0] thr,
                           input int src, input int sink, input bit fill_first);
    src_idle_pct   <= src;
    sink_stall_pct <= sink;
    if (write_thr) write_threshold(thr);
    else @(posedge clk);
    // push at least two beats past capacity, then a retransmit on the full store
    if (fill_first) begin
      repeat (CAPACITY + 2)
        send_beat(ACT_ORD, TAG_BITS'($urandom_range(16'hFFFF)), rand_lid(),
                  PH_W'($urandom_range(3)), PH_NONE);
      send_beat(ACT_HEAD, TAG_BITS'($urandom_range(16'hFFFF)), rand_lid(),
                PH_W'($urandom_range(3)), PH_NONE);
    end
    for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random((n / 80) % 2 == 0);
    in_valid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty queue, lid extremes and ties, every phase filter, clean
    send_beat(ACT_DEQ,   16'h0000, 8'd0,   2'd0, 2'd0);
    send_beat(ACT_ORD,   16'h0000, 8'd0,   2'd0, 2'd0);
    send_beat(ACT_ORD,   16'hFFFF, 8'd255, 2'd3, 2'd3);
    send_beat(ACT_ORD,   16'h1234, 8'd255, 2'd2, 2'd0);
    send_beat(ACT_ORD,   16'h5555, 8'd128, 2'd1, 2'd0);
    send_beat(ACT_HEAD,  16'hAAAA, 8'd7,   2'd2, 2'd1);
    send_beat(ACT_DEQ,   16'h0000, 8'd0,   2'd0, 2'd3);
    send_beat(ACT_DEQ,   16'h0000, 8'd0,   2'd0, 2'd1);
    send_beat(ACT_DEQ,   16'hFFFF, 8'd255, 2'd3, 2'd2);
    send_beat(ACT_DEQ,   16'h0000, 8'd0,   2'd0, 2'd3);
    send_beat(ACT_DEQ,   16'h0000, 8'd0,   2'd0, 2'd0);
    send_beat(ACT_HEAD,  16'h00FF, 8'd1,   2'd3, 2'd0);
    send_beat(ACT_HEAD,  16'hFF00, 8'd254, 2'd3, 2'd0);
    send_beat(ACT_DEQ,   16'h0000, 8'd0,   2'd0, 2'd1);
    send_beat(ACT_DEQ,   16'h0000, 8'd0,   2'd0, 2'd2);
    send_beat(ACT_CLEAN, 16'h0000, 8'd0,   2'd0, 2'd0);
    send_beat(ACT_DEQ,   16'h0000, 8'd0,   2'd0, 2'd2);
    send_beat(ACT_CLEAN, 16'hFFFF, 8'd255, 2'd3, 2'd3);
    send_beat(ACT_HEAD,  16'hFFFF, 8'd255, 2'd0, 2'd0);
    send_beat(ACT_ORD,   16'h8001, 8'd0,   2'd1, 2'd0);
    send_beat(ACT_DEQ,   16'h0000, 8'd0,   2'd0, 2'd3);
    send_beat(ACT_CLEAN, 16'h0000, 8'd0,   2'd0, 2'd0);
    in_valid <= 1'b0;
    wait_drained();

    run_phase(1'b0, THR_RESET, 0,  0,  1'b0);
    run_phase(1'b1, 6'd63,     77, 0,  1'b1);
    run_phase(1'b1, 6'd0,      0,  77, 1'b0);
    run_phase(1'b1, 6'd7,      22, 22, 1'b0);
    run_phase(1'b1, 6'd32,     0,  0,  1'b1);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/otq_pkg.sv
src/otq_cmp.sv
src/otq_slot_ram.sv
src/otq_seq.sv
src/ordered_tx_queue_phase_dequeue_core.sv
tb/otq_checker.sv
tb/tb_ordered_tx_queue_phase_dequeue_core.sv
